// ===== rtl/core/fsc_pkg.sv =====
// ---------------------------------------------------------------------------
// fsc_pkg: shared types, grids and lookup functions
// Four-square cipher over two fixed 6x6 symbol grids.
// ---------------------------------------------------------------------------
package fsc_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] text_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	localparam int GRID_SIDE = 6;
	localparam int RES_MAX   = 3;

	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_EOL  = 1'b1;

	localparam logic [7:0] UNKNOWN_MARK = 8'h23;
	localparam logic [7:0] PAD_BYTE     = 8'h20;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	typedef logic [2:0] grid_idx_t;

	// Cell 0 sits in the most significant byte, row-major order
	localparam logic [0:5][0:5][7:0] PLAIN_GRID =
		"abcdefghijklmnopqrstuvwxyz!?.,()\"/: ";
	localparam logic [0:5][0:5][7:0] KEYED_GRID =
		"hq/nkracuo\"tslfb(vpx:mg?i!zjeyd ,w).";

	typedef struct packed {
		logic      found;
		grid_idx_t row;
		grid_idx_t col;
	} grid_hit_t;

	typedef struct packed {
		logic       decrypt;
		logic [7:0] a;
		logic [7:0] b;
		grid_idx_t  kcol_first;
		grid_idx_t  kcol_second;
	} pair_req_t;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		grid_idx_t  kcol_first;
		grid_idx_t  kcol_second;
	} pair_res_t;

	function automatic logic [7:0] to_lower(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	// Symbols are unique in each grid, so at most one cell matches
	function automatic grid_hit_t grid_find(logic keyed, logic [7:0] c);
		grid_hit_t hit;
		logic [7:0] sym;
		hit = '0;
		for (int r = 0; r < GRID_SIDE; r++) begin
			for (int k = 0; k < GRID_SIDE; k++) begin
				sym = keyed ? KEYED_GRID[r][k] : PLAIN_GRID[r][k];
				if (sym == c) begin
					hit.found = 1'b1;
					hit.row   = grid_idx_t'(r);
					hit.col   = grid_idx_t'(k);
				end
			end
		end
		return hit;
	endfunction

	function automatic logic [7:0] grid_char(logic keyed, grid_idx_t row, grid_idx_t col);
		return keyed ? KEYED_GRID[row][col] : PLAIN_GRID[row][col];
	endfunction

endpackage

// ===== rtl/core/four_square_cipher_6x6.sv =====
// ---------------------------------------------------------------------------
// four_square_cipher_6x6: streaming four-square cipher, 6x6 grids
// Lowercases and pairs text bytes, emits cipher bytes and line ends.
// ---------------------------------------------------------------------------
//  Channel   Handshake                 Payload      Transaction
//  in        in_valid / in_stall       in_data      one text byte or end of line
//  out       out_valid / out_stall     out_data     one result byte
//  cfg       psel/penable/pwrite/...   pwdata[0]    decrypt_mode at address 0
//
//  An item is registered in item_s1; its results are then written into the
//  result queue, which drives out. A new item is taken every cycle while
//  the queue (four entries) has room for three results after this cycle's
//  pop, so the sustained rate is set by the output port: one result per cycle.
//  Reset clears the pair state, kept columns, mode and queue.
//  A stall on out backs up through the queue into in_stall.
// ---------------------------------------------------------------------------
module four_square_cipher_6x6 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fsc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fsc_pkg::out_item_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic                decrypt_q;
	logic                valid_s1;
	fsc_pkg::in_item_t   item_s1;
	logic [7:0]          pending_q;
	logic                have_pending_q;
	fsc_pkg::grid_idx_t  kcol_first_q;
	fsc_pkg::grid_idx_t  kcol_second_q;

	logic [2:0]          q_count;
	logic [2:0]          q_after_pop;
	logic                advance;
	logic [7:0]          c_low;
	logic [1:0]          push_n;
	fsc_pkg::out_item_t  push_data [fsc_pkg::RES_MAX];
	fsc_pkg::pair_req_t  pair_req;
	fsc_pkg::pair_res_t  pair_res;

	// config port
	assign pready = 1'b1;
	assign prdata = {31'd0, decrypt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			decrypt_q <= pwdata[0];
		end
	end

	// issue control
	assign q_after_pop = q_count - 3'(out_valid && !out_stall);
	assign advance     = valid_s1 && (q_after_pop <= 3'd1);
	assign in_stall    = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_data;
		end
	end

	// pair lookup
	assign c_low = fsc_pkg::to_lower(item_s1.text_byte);

	always_comb begin
		pair_req.decrypt     = decrypt_q;
		pair_req.a           = pending_q;
		pair_req.b           = (item_s1.cmd == fsc_pkg::CMD_EOL) ? fsc_pkg::PAD_BYTE : c_low;
		pair_req.kcol_first  = kcol_first_q;
		pair_req.kcol_second = kcol_second_q;
	end

	fsc_pair u_pair (
		.req (pair_req),
		.res (pair_res)
	);

	always_comb begin
		push_n       = 2'd0;
		push_data[0] = '{out_byte: pair_res.byte0, last_of_run: 1'b0};
		push_data[1] = '{out_byte: pair_res.byte1, last_of_run: 1'b1};
		push_data[2] = '{out_byte: fsc_pkg::NEWLINE_BYTE, last_of_run: 1'b1};
		if (advance) begin
			if (item_s1.cmd == fsc_pkg::CMD_TEXT) begin
				push_n = have_pending_q ? 2'd2 : 2'd0;
			end else if (have_pending_q) begin
				push_n = 2'd3;
				push_data[1].last_of_run = 1'b0;
			end else begin
				push_n = 2'd1;
				push_data[0] = '{out_byte: fsc_pkg::NEWLINE_BYTE, last_of_run: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pending_q <= 1'b0;
			kcol_first_q   <= '0;
			kcol_second_q  <= '0;
		end else if (advance) begin
			if (item_s1.cmd == fsc_pkg::CMD_TEXT && !have_pending_q) begin
				have_pending_q <= 1'b1;
			end else begin
				have_pending_q <= 1'b0;
				if (have_pending_q) begin
					kcol_first_q  <= pair_res.kcol_first;
					kcol_second_q <= pair_res.kcol_second;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.cmd == fsc_pkg::CMD_TEXT && !have_pending_q) begin
			pending_q <= c_low;
		end
	end

	fsc_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (push_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.count     (q_count)
	);

	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_of_run |-> q_count >= 3'd2)
		else $error("partial result run in queue");

	a_eol_closes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == fsc_pkg::CMD_EOL |=> !have_pending_q)
		else $error("pair left open after end of line");

	a_first_opens: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == fsc_pkg::CMD_TEXT && !have_pending_q |=> have_pending_q)
		else $error("first byte did not open a pair");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		kcol_first_q < 3'(fsc_pkg::GRID_SIDE) && kcol_second_q < 3'(fsc_pkg::GRID_SIDE))
		else $error("kept column out of range");

endmodule

// ===== rtl/core/fsc_pair.sv =====
// ---------------------------------------------------------------------------
// fsc_pair: four-square lookup of one byte pair
// Finds both bytes in the input grid and swaps columns into the output grid.
// ---------------------------------------------------------------------------
module fsc_pair (
	input  fsc_pkg::pair_req_t req,
	output fsc_pkg::pair_res_t res
);

	fsc_pkg::grid_hit_t hit_a;
	fsc_pkg::grid_hit_t hit_b;
	fsc_pkg::grid_idx_t kcf;
	fsc_pkg::grid_idx_t kcs;

	always_comb begin
		hit_a = fsc_pkg::grid_find(req.decrypt, req.a);
		hit_b = fsc_pkg::grid_find(req.decrypt, req.b);
		// a miss leaves the column from the last hit in place
		kcs = hit_a.found ? hit_a.col : req.kcol_second;
		kcf = hit_b.found ? hit_b.col : req.kcol_first;
		res.kcol_first  = kcf;
		res.kcol_second = kcs;
		res.byte0 = hit_a.found ? fsc_pkg::grid_char(!req.decrypt, hit_a.row, kcf)
		                        : fsc_pkg::UNKNOWN_MARK;
		res.byte1 = hit_b.found ? fsc_pkg::grid_char(!req.decrypt, hit_b.row, kcs)
		                        : fsc_pkg::UNKNOWN_MARK;
	end

endmodule

// ===== rtl/core/fsc_rfifo.sv =====
// ---------------------------------------------------------------------------
// fsc_rfifo: result queue
// Four entries; takes up to three results per cycle, gives one per cycle while out is not stalled.
// ---------------------------------------------------------------------------
module fsc_rfifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            push_n,
	input  fsc_pkg::out_item_t    push_data [fsc_pkg::RES_MAX],
	output logic                  out_valid,
	input  logic                  out_stall,
	output fsc_pkg::out_item_t    out_data,
	output logic [2:0]            count
);

	localparam int DEPTH = 4;

	fsc_pkg::out_item_t mem_q [DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 3'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < fsc_pkg::RES_MAX; k++) begin
			if (2'(k) < push_n) begin
				mem_q[wr_ptr_q + 2'(k)] <= push_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			count_q  <= count_q + 3'(push_n) - 3'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(DEPTH))
		else $error("result queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 3'd0 |=> count_q <= 3'd3)
		else $error("result queue grew past three from empty");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 3'd0 || count_q == 3'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("result queue pointers disagree with count");

endmodule

// ===== test/tb_four_square_cipher_6x6.sv =====
// ---------------------------------------------------------------------------
// tb_four_square_cipher_6x6: self-checking bench for the four-square cipher
// Drives text bytes and line ends with random gaps and output stalls, flips
// the cipher direction over APB between phases, and checks every output
// byte against an in-bench cipher model held in a small scoreboard.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_square_cipher_6x6;

	localparam int       SIDE          = 6;
	localparam int       CELLS         = 36;
	localparam int       CYCLE_LIMIT   = 60000;
	localparam int       SETTLE_CYCLES = 8;
	localparam int       PHASE_ITEMS   = 38;
	localparam logic [2:0] DECRYPT_MODE_ADDR = 3'd0;

	// Cell 0 in the top byte
	localparam logic [8*CELLS-1:0] PLAIN_SYMBOLS =
		"abcdefghijklmnopqrstuvwxyz!?.,()\"/: ";
	localparam logic [8*CELLS-1:0] KEYED_SYMBOLS =
		"hq/nkracuo\"tslfb(vpx:mg?i!zjeyd ,w).";

	class cipher_scoreboard;
		bit                  decrypt;
		bit [7:0]            held_byte;
		bit                  holding;
		bit [2:0]            col_for_first;
		bit [2:0]            col_for_second;
		fsc_pkg::out_item_t  cipher_out_q[$];
		int                  errors;

		function bit [7:0] lowercase(bit [7:0] c);
			if (c >= 8'h41 && c <= 8'h5A) begin
				return c + 8'h20;
			end
			return c;
		endfunction

		function bit [7:0] symbol_at(bit keyed, int row, int col);
			int idx;
			idx = row * SIDE + col;
			return keyed ? KEYED_SYMBOLS[8*(CELLS-1-idx) +: 8]
			             : PLAIN_SYMBOLS[8*(CELLS-1-idx) +: 8];
		endfunction

		function bit locate(bit keyed, bit [7:0] c, output int row, output int col);
			row = 0;
			col = 0;
			for (int i = 0; i < CELLS; i++) begin
				if (symbol_at(keyed, i / SIDE, i % SIDE) == c) begin
					row = i / SIDE;
					col = i % SIDE;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void push_result(bit [7:0] b, bit last);
			fsc_pkg::out_item_t r;
			r.out_byte    = b;
			r.last_of_run = last;
			cipher_out_q = {cipher_out_q, r};
		endfunction

		// Both kept columns update before either output byte is formed
		function void encipher_pair(bit [7:0] a, bit [7:0] b, bit closes_run);
			int  row_a, col_a, row_b, col_b;
			bit  hit_a, hit_b;
			hit_a = locate(decrypt, a, row_a, col_a);
			hit_b = locate(decrypt, b, row_b, col_b);
			if (hit_a) begin
				col_for_second = 3'(col_a);
			end
			if (hit_b) begin
				col_for_first = 3'(col_b);
			end
			push_result(hit_a ? symbol_at(!decrypt, row_a, int'(col_for_first))
			                  : fsc_pkg::UNKNOWN_MARK, 1'b0);
			push_result(hit_b ? symbol_at(!decrypt, row_b, int'(col_for_second))
			                  : fsc_pkg::UNKNOWN_MARK, closes_run);
		endfunction

		function void set_mode(bit m);
			decrypt = m;
		endfunction

		function void note_input(fsc_pkg::in_item_t it);
			bit [7:0] c;
			c = lowercase(it.text_byte);
			if (it.cmd == fsc_pkg::CMD_TEXT) begin
				if (!holding) begin
					held_byte = c;
					holding   = 1'b1;
				end else begin
					encipher_pair(held_byte, c, 1'b1);
					holding = 1'b0;
				end
			end else begin
				if (holding) begin
					encipher_pair(held_byte, fsc_pkg::PAD_BYTE, 1'b0);
					holding = 1'b0;
				end
				push_result(fsc_pkg::NEWLINE_BYTE, 1'b1);
			end
		endfunction

		function void check_result(fsc_pkg::out_item_t got);
			fsc_pkg::out_item_t want;
			if (cipher_out_q.size() == 0) begin
				$error("unexpected output transaction: out_byte %h last_of_run %b",
					got.out_byte, got.last_of_run);
				errors++;
				return;
			end
			want = cipher_out_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %b, actual %b", want.last_of_run,
					got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	fsc_pkg::in_item_t   in_data;
	logic                out_valid;
	logic                out_stall = 1'b0;
	fsc_pkg::out_item_t  out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	cipher_scoreboard sb = new();
	bit  no_gaps;
	int  cycle_count;

	four_square_cipher_6x6 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= !no_gaps && ($urandom_range(99) < 18);
	end

	// Observe accepted transactions on all three ports
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (psel && penable && pwrite && pready && paddr == DECRYPT_MODE_ADDR) begin
				sb.set_mode(pwdata[0]);
			end
			if (in_valid && !in_stall) begin
				sb.note_input(in_data);
			end
			if (out_valid && !out_stall) begin
				sb.check_result(out_data);
			end
		end
	end

	task automatic send_item(fsc_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_text(logic [7:0] c);
		fsc_pkg::in_item_t it;
		it.cmd       = fsc_pkg::CMD_TEXT;
		it.text_byte = c;
		send_item(it);
	endtask

	task automatic send_eol(logic [7:0] junk);
		fsc_pkg::in_item_t it;
		it.cmd       = fsc_pkg::CMD_EOL;
		it.text_byte = junk;
		send_item(it);
	endtask

	// A lone first byte leaves nothing queued, so allow for latency too
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.cipher_out_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DECRYPT_MODE_ADDR;
		pwdata  <= {31'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly grid symbols (some uppercased), plus line ends and raw bytes
	function automatic fsc_pkg::in_item_t random_item();
		fsc_pkg::in_item_t it;
		int       pick;
		int       idx;
		logic [7:0] c;
		pick = $urandom_range(99);
		idx  = $urandom_range(CELLS - 1);
		it.cmd       = fsc_pkg::CMD_TEXT;
		it.text_byte = 8'($urandom_range(255));
		if (pick < 10) begin
			it.cmd = fsc_pkg::CMD_EOL;
		end else if (pick >= 25) begin
			c = PLAIN_SYMBOLS[8*(CELLS-1-idx) +: 8];
			if (c >= 8'h61 && c <= 8'h7A && $urandom_range(3) == 0) begin
				c = c - 8'h20;
			end
			it.text_byte = c;
		end
		return it;
	endfunction

	initial begin
		logic phase_mode [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		cycle_count <= 0;
		no_gaps  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: case folding, grid corners, unknown symbols, padding
		send_text("A");
		send_text("z");
		send_text(" ");
		send_text("a");
		send_eol(8'hFF);
		send_text(8'h00);
		send_text(8'hFF);
		send_text(8'h40);
		send_text("m");
		send_text("Z");
		send_text(8'h5B);
		send_text("q");
		send_eol(8'h00);

		// Direction flipped between the two bytes of a pair
		send_text("h");
		settle();
		write_mode(1'b1);
		send_text("Q");
		send_text("\"");
		send_text(".");
		send_text(":");
		send_eol(8'h5A);
		send_text("!");
		send_eol(8'h20);

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_mode(phase_mode[ph]);
			no_gaps = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (!no_gaps && $urandom_range(99) < 18) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
				send_item(random_item());
			end
		end

		no_gaps = 1'b0;
		settle();
		if (sb.errors == 0 && sb.cipher_out_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
